// File: rtl/rrg_pkg.sv
package rrg_pkg;

    // Input mode codes.
    localparam logic [2:0] MODE_KEY  = 3'd0;
    localparam logic [2:0] MODE_W32  = 3'd1;
    localparam logic [2:0] MODE_W64  = 3'd2;
    localparam logic [2:0] MODE_RUN  = 3'd3;
    localparam logic [2:0] MODE_TICK = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_RUNS = 2'd0;
    localparam logic [1:0] CFG_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_DISCARD  = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] MAX_RUNS_RST = 16'd16384;
    localparam logic [15:0] INTERVAL_RST = 16'd300;
    localparam logic [11:0] DISCARD_RST  = 12'd3072;

    localparam logic [16:0] RUN_COUNT_MAX = 17'h1FFFF;

    typedef enum logic [2:0] {
        KIND_KEY,
        KIND_TICK,
        KIND_W32,
        KIND_W64,
        KIND_RUN
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  key_byte;
        logic        key_last;
        logic [6:0]  count;
    } cmd_t;

    typedef struct packed {
        logic [63:0] value;
        logic        last;
        logic        restirred;
    } result_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_REQ,
        ST_KS0,
        ST_KS1,
        ST_KS2,
        ST_KS3,
        ST_B0,
        ST_B1,
        ST_B2,
        ST_B3,
        ST_B4,
        ST_B5,
        ST_FIN
    } state_t;

endpackage

// File: rtl/rrg_front.sv
module rrg_front #(
    parameter int MAX_BYTE_RUN = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_accept,
    input  logic [2:0]      mode,
    input  logic [7:0]      key_byte,
    input  logic            key_last,
    input  logic [6:0]      byte_count,
    output logic            q_full,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output rrg_pkg::cmd_t   cmd
);
    import rrg_pkg::*;

    localparam logic [6:0] RUN_MAX = 7'(MAX_BYTE_RUN);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       cls;
    logic       cls_ok;
    logic       do_push;
    logic       do_pop;

    // Classify the incoming item; unused modes are dropped.
    always_comb
    begin
        cls.key_byte = key_byte;
        cls.key_last = key_last;
        cls.kind     = KIND_KEY;
        cls_ok       = 1'b1;
        if (byte_count == 7'd0)
        begin
            cls.count = 7'd1;
        end
        else if (byte_count > RUN_MAX)
        begin
            cls.count = RUN_MAX;
        end
        else
        begin
            cls.count = byte_count;
        end
        unique case (mode)
            MODE_KEY:  cls.kind = KIND_KEY;
            MODE_W32:  cls.kind = KIND_W32;
            MODE_W64:  cls.kind = KIND_W64;
            MODE_RUN:  cls.kind = KIND_RUN;
            MODE_TICK: cls.kind = KIND_TICK;
            default:   cls_ok   = 1'b0;
        endcase
    end

    assign q_full    = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign do_push   = in_accept && cls_ok;
    assign do_pop    = cmd_valid && cmd_ready;

    // Command queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// File: rtl/rrg_outq.sv
module rrg_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rrg_pkg::result_t  din,
    output logic              full,
    input  logic              pop,
    output rrg_pkg::result_t  dout,
    output logic              empty
);
    import rrg_pkg::*;

    result_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign dout    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// File: rtl/rrg_core.sv
module rrg_core #(
    parameter int KEY_BYTES = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  rrg_pkg::cmd_t     cmd,
    output logic              cmd_ready,
    input  logic              res_full,
    output logic              res_push,
    output rrg_pkg::result_t  res,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output logic              init_busy
);
    import rrg_pkg::*;

    localparam int KIW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int LW  = $clog2(KEY_BYTES + 1);
    localparam logic [LW-1:0] KEY_FULL = LW'(KEY_BYTES);

    // Permutation table and key store.
    logic [7:0]     perm_mem [256];
    logic [7:0]     key_mem  [KEY_BYTES];
    logic [7:0]     perm_q;
    logic [7:0]     key_q;

    state_t         state_reg;
    state_t         state_next;

    logic [15:0]    max_runs_reg;
    logic [15:0]    interval_reg;
    logic [11:0]    discard_reg;

    logic [7:0]     i_reg;
    logic [7:0]     j_reg;
    logic [7:0]     n_reg;
    logic [KIW-1:0] kidx_reg;
    logic [LW-1:0]  key_len_reg;
    logic [LW-1:0]  load_pos_reg;
    logic [16:0]    run_count_reg;
    logic [31:0]    uptime_reg;
    logic [31:0]    deadline_reg;
    logic           seeded_reg;
    logic           pend_reg;
    logic           disc_reg;
    logic           rs_reg;
    logic [12:0]    dcnt_reg;
    logic [6:0]     bcnt_reg;
    kind_t          kind_reg;
    logic [7:0]     a_reg;
    logic [7:0]     b_reg;
    logic [63:0]    wacc_reg;

    // Memory port controls.
    logic           p_re;
    logic [7:0]     p_ra;
    logic           p_we;
    logic [7:0]     p_wa;
    logic [7:0]     p_wd;
    logic           k_we;

    logic [7:0]     key_val;
    logic [7:0]     ks_j;
    logic [16:0]    rc_inc;
    logic [31:0]    age;
    logic           passed;
    logic           force_stir;
    logic [12:0]    disc_total;
    logic           out_step;
    logic [63:0]    wacc_next;

    // Request checks.
    assign rc_inc     = (run_count_reg < RUN_COUNT_MAX) ? run_count_reg + 17'd1 : run_count_reg;
    assign age        = uptime_reg - deadline_reg;
    assign passed     = (age != 32'd0) && !age[31];
    assign force_stir = (rc_inc > {1'b0, max_runs_reg}) || passed || !seeded_reg;
    assign disc_total = seeded_reg ? {1'b0, discard_reg} : {discard_reg, 1'b0};

    assign key_val    = (key_len_reg == '0) ? 8'd0 : key_q;
    assign ks_j       = j_reg + perm_q + key_val;
    assign wacc_next  = {perm_q, wacc_reg[63:8]};

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign init_busy  = (state_reg == ST_INIT);
    assign out_step   = (state_reg == ST_B5) && !disc_reg && !res_full;

    // Words are emitted once their last byte is in; byte runs emit every byte.
    assign res_push   = out_step && ((kind_reg == KIND_RUN) || (bcnt_reg == 7'd1));

    // Result formatting.
    always_comb
    begin
        res.restirred = rs_reg;
        res.last      = 1'b1;
        unique case (kind_reg)
            KIND_W64: res.value = wacc_next;
            KIND_W32: res.value = {32'd0, wacc_next[63:32]};
            default:
            begin
                res.value = {56'd0, perm_q};
                res.last  = (bcnt_reg == 7'd1);
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (n_reg == 8'd255)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    priority case (cmd.kind)
                        KIND_KEY:  state_next = cmd.key_last ? ST_KS0 : ST_IDLE;
                        KIND_TICK: state_next = ST_IDLE;
                        default:   state_next = ST_REQ;
                    endcase
                end
            end
            ST_REQ:  state_next = force_stir ? ST_KS0 : ST_B0;
            ST_KS0:  state_next = ST_KS1;
            ST_KS1:  state_next = ST_KS2;
            ST_KS2:  state_next = ST_KS3;
            ST_KS3:
            begin
                if (n_reg != 8'd255)
                begin
                    state_next = ST_KS0;
                end
                else if (disc_total == 13'd0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_B0;
                end
            end
            ST_B0:   state_next = ST_B1;
            ST_B1:   state_next = ST_B2;
            ST_B2:   state_next = ST_B3;
            ST_B3:   state_next = ST_B4;
            ST_B4:   state_next = ST_B5;
            ST_B5:
            begin
                if (disc_reg)
                begin
                    state_next = (dcnt_reg == 13'd1) ? ST_FIN : ST_B0;
                end
                else if (!res_full)
                begin
                    state_next = (bcnt_reg == 7'd1) ? ST_IDLE : ST_B0;
                end
            end
            ST_FIN:  state_next = pend_reg ? ST_B0 : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory port controls per state.
    always_comb
    begin
        p_re = 1'b0;
        p_ra = 8'd0;
        p_we = 1'b0;
        p_wa = 8'd0;
        p_wd = 8'd0;
        k_we = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                p_we = 1'b1;
                p_wa = n_reg;
                p_wd = n_reg;
            end
            ST_IDLE:
            begin
                k_we = cmd_valid && (cmd.kind == KIND_KEY) && (load_pos_reg < KEY_FULL);
            end
            ST_KS0:
            begin
                p_re = 1'b1;
                p_ra = n_reg;
            end
            ST_KS1:
            begin
                p_re = 1'b1;
                p_ra = ks_j;
            end
            ST_KS2:
            begin
                p_we = 1'b1;
                p_wa = n_reg;
                p_wd = perm_q;
            end
            ST_KS3:
            begin
                p_we = 1'b1;
                p_wa = j_reg;
                p_wd = a_reg;
            end
            ST_B0:
            begin
                p_re = 1'b1;
                p_ra = i_reg + 8'd1;
            end
            ST_B1:
            begin
                p_re = 1'b1;
                p_ra = j_reg + perm_q;
            end
            ST_B2:
            begin
                p_we = 1'b1;
                p_wa = i_reg;
                p_wd = perm_q;
            end
            ST_B3:
            begin
                p_we = 1'b1;
                p_wa = j_reg;
                p_wd = a_reg;
            end
            ST_B4:
            begin
                p_re = 1'b1;
                p_ra = a_reg + b_reg;
            end
            default:
            begin
                p_re = 1'b0;
            end
        endcase
    end

    // Permutation table memory.
    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            perm_mem[p_wa] <= p_wd;
        end
        if (p_re)
        begin
            perm_q <= perm_mem[p_ra];
        end
    end

    // Key store memory.
    always_ff @(posedge clk)
    begin
        if (k_we)
        begin
            key_mem[load_pos_reg[KIW-1:0]] <= cmd.key_byte;
        end
        key_q <= key_mem[kidx_reg];
    end

    // Byte datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_KS1 || state_reg == ST_B1)
        begin
            a_reg <= perm_q;
        end
        if (state_reg == ST_B2)
        begin
            b_reg <= perm_q;
        end
        if (out_step)
        begin
            wacc_reg <= wacc_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_runs_reg <= MAX_RUNS_RST;
            interval_reg <= INTERVAL_RST;
            discard_reg  <= DISCARD_RST;
        end
        else if (cfg_valid)
        begin
            priority case (cfg_index)
                CFG_MAX_RUNS: max_runs_reg <= cfg_data;
                CFG_INTERVAL: interval_reg <= cfg_data;
                CFG_DISCARD:  discard_reg  <= cfg_data[11:0];
                default:      max_runs_reg <= max_runs_reg;
            endcase
        end
    end

    // Control and generator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            i_reg         <= 8'd0;
            j_reg         <= 8'd0;
            n_reg         <= 8'd0;
            kidx_reg      <= '0;
            key_len_reg   <= '0;
            load_pos_reg  <= '0;
            run_count_reg <= 17'd0;
            uptime_reg    <= 32'd0;
            deadline_reg  <= 32'd0;
            seeded_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            disc_reg      <= 1'b0;
            rs_reg        <= 1'b0;
            dcnt_reg      <= 13'd0;
            bcnt_reg      <= 7'd0;
            kind_reg      <= KIND_W32;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_INIT:
                begin
                    n_reg <= n_reg + 8'd1;
                end
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        kind_reg <= cmd.kind;
                        pend_reg <= 1'b0;
                        priority case (cmd.kind)
                            KIND_KEY:
                            begin
                                if (cmd.key_last)
                                begin
                                    key_len_reg  <= k_we ? load_pos_reg + LW'(1)
                                                         : load_pos_reg;
                                    load_pos_reg <= '0;
                                    n_reg        <= 8'd0;
                                    kidx_reg     <= '0;
                                end
                                else if (k_we)
                                begin
                                    load_pos_reg <= load_pos_reg + LW'(1);
                                end
                            end
                            KIND_TICK: uptime_reg <= uptime_reg + 32'd1;
                            KIND_W32:  bcnt_reg   <= 7'd4;
                            KIND_W64:  bcnt_reg   <= 7'd8;
                            default:   bcnt_reg   <= cmd.count;
                        endcase
                    end
                end
                ST_REQ:
                begin
                    run_count_reg <= rc_inc;
                    rs_reg        <= force_stir;
                    pend_reg      <= force_stir;
                    disc_reg      <= 1'b0;
                    n_reg         <= 8'd0;
                    kidx_reg      <= '0;
                end
                ST_KS1:
                begin
                    j_reg <= ks_j;
                end
                ST_KS3:
                begin
                    n_reg <= n_reg + 8'd1;
                    if (LW'(kidx_reg) + LW'(1) == key_len_reg)
                    begin
                        kidx_reg <= '0;
                    end
                    else
                    begin
                        kidx_reg <= kidx_reg + KIW'(1);
                    end
                    dcnt_reg <= disc_total;
                    disc_reg <= 1'b1;
                end
                ST_B0:
                begin
                    i_reg <= i_reg + 8'd1;
                end
                ST_B1:
                begin
                    j_reg <= j_reg + perm_q;
                end
                ST_B5:
                begin
                    if (disc_reg)
                    begin
                        dcnt_reg <= dcnt_reg - 13'd1;
                    end
                    else if (!res_full)
                    begin
                        bcnt_reg <= bcnt_reg - 7'd1;
                    end
                end
                ST_FIN:
                begin
                    deadline_reg  <= uptime_reg + {16'd0, interval_reg};
                    run_count_reg <= 17'd0;
                    seeded_reg    <= 1'b1;
                    disc_reg      <= 1'b0;
                    pend_reg      <= 1'b0;
                end
                default:
                begin
                    n_reg <= n_reg;
                end
            endcase
        end
    end

endmodule

// File: rtl/rc4_reseeding_random_generator_unit.sv
// RC4 keystream generator with automatic reseeding. After reset the block
// loads the identity permutation into the table and holds full high meanwhile.
// Each keystream byte steps through states B0 to B5 on the permutation table
// (two dependent reads, two swap writes and the output read), and a request
// first passes dispatch in IDLE and the checks in REQ. A stir runs the key
// schedule over all 256 entries, then the discarded bytes (twice the discard
// count on the first stir), then a closing state.
// Ticks and key bytes other than the last are taken in the idle state.
// Commands wait in a two-entry queue and results in a two-entry queue, so
// either side may stall independently.
module rc4_reseeding_random_generator_unit #(
    parameter int KEY_BYTES    = 32,
    parameter int MAX_BYTE_RUN = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  mode,
    input  logic [7:0]  key_byte,
    input  logic        key_last,
    input  logic [6:0]  byte_count,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] random_value,
    output logic        run_last,
    output logic        restirred,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import rrg_pkg::*;

    logic    q_full;
    logic    init_busy;
    logic    in_accept;
    logic    cmd_valid;
    logic    cmd_ready;
    cmd_t    cmd;
    logic    res_full;
    logic    res_push;
    result_t res;
    result_t res_out;

    assign full      = q_full || init_busy;
    assign in_accept = push && !full;
    assign cfg_ready = 1'b1;

    // Front end: classify and queue commands.
    rrg_front #(
        .MAX_BYTE_RUN (MAX_BYTE_RUN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_accept),
        .mode       (mode),
        .key_byte   (key_byte),
        .key_last   (key_last),
        .byte_count (byte_count),
        .q_full     (q_full),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    // Back end: key schedule and keystream engine.
    rrg_core #(
        .KEY_BYTES (KEY_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .init_busy (init_busy)
    );

    // Result queue toward the consumer.
    rrg_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty)
    );

    assign random_value = res_out.value;
    assign run_last     = res_out.last;
    assign restirred    = res_out.restirred;

endmodule

// File: dv/rc4_reseeding_random_generator_unit_test.sv
`timescale 1ns / 1ps

module rc4_reseeding_random_generator_unit_test;
    import rrg_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  mode = MODE_TICK;
    logic [7:0]  key_byte = 8'd0;
    logic        key_last = 1'b0;
    logic [6:0]  byte_count = 7'd1;
    logic        empty;
    logic        pop = 1'b0;
    logic [63:0] random_value;
    logic        run_last;
    logic        restirred;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_MAX_RUNS;
    logic [15:0] cfg_data = 16'd0;

    rc4_reseeding_random_generator_unit u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .mode(mode),
        .key_byte(key_byte), .key_last(key_last), .byte_count(byte_count),
        .empty(empty), .pop(pop), .random_value(random_value),
        .run_last(run_last), .restirred(restirred), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock generation.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Keystream generator state mirrored by the predictor.
    logic [7:0]  perm [256];
    logic [7:0]  idx_i;
    logic [7:0]  idx_j;
    logic [7:0]  key_mem [32];
    int          key_len;
    int          load_pos;
    logic [16:0] req_count;
    logic [31:0] uptime;
    logic [31:0] deadline;
    logic        seeded;
    logic [15:0] max_runs_reg;
    logic [15:0] interval_reg;
    logic [11:0] discard_reg;

    result_t     expected_results [$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          recv_hold = 0;

    function automatic logic [7:0] keystream_byte();
        logic [7:0] a;
        logic [7:0] b;
        idx_i = idx_i + 8'd1;
        a = perm[idx_i];
        idx_j = idx_j + a;
        b = perm[idx_j];
        perm[idx_i] = b;
        perm[idx_j] = a;
        return perm[8'(a + b)];
    endfunction

    function automatic void drop_bytes();
        for (int n = 0; n < discard_reg; n++)
            void'(keystream_byte());
    endfunction

    // Key scheduling with the stored key repeated, then the discard.
    function automatic void stir_table();
        logic [7:0] k;
        logic [7:0] t;
        for (int n = 0; n < 256; n++)
        begin
            k = (key_len != 0) ? key_mem[n % key_len] : 8'd0;
            idx_j = idx_j + perm[n] + k;
            t = perm[n];
            perm[n] = perm[idx_j];
            perm[idx_j] = t;
        end
        drop_bytes();
        if (!seeded)
        begin
            drop_bytes();
            seeded = 1'b1;
        end
        deadline = uptime + 32'(interval_reg);
        req_count = '0;
    endfunction

    function automatic logic open_request();
        logic [31:0] diff;
        if (req_count < RUN_COUNT_MAX)
            req_count = req_count + 17'd1;
        diff = uptime - deadline;
        if (req_count > 17'(max_runs_reg) || (diff >= 1 && diff <= 32'h7FFF_FFFF)
            || !seeded)
        begin
            stir_table();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void model_reset();
        for (int n = 0; n < 256; n++)
            perm[n] = 8'(n);
        idx_i = '0;
        idx_j = '0;
        key_len = 0;
        load_pos = 0;
        req_count = '0;
        uptime = '0;
        deadline = '0;
        seeded = 1'b0;
        max_runs_reg = MAX_RUNS_RST;
        interval_reg = INTERVAL_RST;
        discard_reg = DISCARD_RST;
    endfunction

    // Work out the results of one accepted command.
    function automatic void predict_command(logic [2:0] m, logic [7:0] kb, logic kl,
                                            logic [6:0] bc);
        result_t r;
        int cnt;
        logic rs;
        case (m)
            MODE_KEY:
            begin
                if (load_pos < 32)
                begin
                    key_mem[load_pos] = kb;
                    load_pos++;
                end
                if (kl)
                begin
                    key_len = load_pos;
                    load_pos = 0;
                    stir_table();
                end
            end
            MODE_W32, MODE_W64:
            begin
                r.restirred = open_request();
                r.value = '0;
                cnt = (m == MODE_W32) ? 4 : 8;
                for (int n = 0; n < cnt; n++)
                    r.value[8*n +: 8] = keystream_byte();
                r.last = 1'b1;
                expected_results.push_back(r);
            end
            MODE_RUN:
            begin
                cnt = (bc == 0) ? 1 : (bc > 64) ? 64 : int'(bc);
                rs = open_request();
                for (int n = 0; n < cnt; n++)
                begin
                    r.value = {56'd0, keystream_byte()};
                    r.last = (n + 1 == cnt);
                    r.restirred = rs;
                    expected_results.push_back(r);
                end
            end
            MODE_TICK: uptime = uptime + 32'd1;
            default: ;
        endcase
    endfunction

    // Result checking and receiver stalls, including long hold-offs.
    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result value=%h", random_value);
                error_count++;
            end
            else
            begin
                if (random_value !== expected_results[0].value)
                begin
                    $error("random_value expected %h actual %h",
                           expected_results[0].value, random_value);
                    error_count++;
                end
                if (run_last !== expected_results[0].last)
                begin
                    $error("run_last expected %b actual %b",
                           expected_results[0].last, run_last);
                    error_count++;
                end
                if (restirred !== expected_results[0].restirred)
                begin
                    $error("restirred expected %b actual %b",
                           expected_results[0].restirred, restirred);
                    error_count++;
                end
                void'(expected_results.pop_front());
            end
        end
        if (recv_hold > 0)
        begin
            recv_hold <= recv_hold - 1;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // One command transfer, with random sender gaps in front of it.
    task automatic send_item(logic [2:0] m, logic [7:0] kb = 8'd0, logic kl = 1'b0,
                             logic [6:0] bc = 7'd1);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        mode <= m;
        key_byte <= kb;
        key_last <= kl;
        byte_count <= bc;
        do
            @(posedge clk);
        while (full);
        predict_command(m, kb, kl, bc);
    endtask

    // One register write, after which the channel is left idle before the task returns.
    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MAX_RUNS: max_runs_reg = data;
            CFG_INTERVAL: interval_reg = data;
            CFG_DISCARD:  discard_reg = data[11:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Stop sending and wait for every expected result, then a settle time.
    task automatic drain();
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic load_key(int len);
        for (int n = 0; n < len; n++)
            send_item(MODE_KEY, 8'($urandom), n == len - 1);
    endtask

    // The first request after reset stirs from the empty key at reset settings.
    task automatic test_reset_defaults();
        send_item(MODE_W32);
        send_item(MODE_W64);
        drain();
    endtask

    // Field extremes, every mode, overflow loads and forced restirs.
    task automatic test_directed();
        write_reg(CFG_DISCARD, 16'hF005);
        write_reg(CFG_MAX_RUNS, 16'd0);
        write_reg(CFG_INTERVAL, 16'd0);
        write_reg(2'd3, 16'hFFFF);
        send_item(MODE_KEY, 8'hFF, 1'b1);
        send_item(MODE_W32);
        send_item(MODE_RUN, 8'd0, 1'b0, 7'd0);
        send_item(MODE_RUN, 8'd0, 1'b0, 7'd127);
        send_item(3'd5, 8'hAA, 1'b1, 7'd5);
        send_item(3'd7, 8'h55, 1'b0, 7'd64);
        send_item(3'd6);
        drain();
        write_reg(CFG_MAX_RUNS, 16'd2);
        write_reg(CFG_INTERVAL, 16'd1);
        send_item(MODE_W64);
        send_item(MODE_TICK);
        send_item(MODE_W32);
        send_item(MODE_TICK);
        send_item(MODE_TICK);
        send_item(MODE_RUN, 8'd0, 1'b0, 7'd64);
        send_item(MODE_W32);
        send_item(MODE_W32);
        drain();
        write_reg(CFG_DISCARD, 16'd4095);
        write_reg(CFG_MAX_RUNS, 16'hFFFF);
        write_reg(CFG_INTERVAL, 16'hFFFF);
        load_key(40);
        send_item(MODE_W64);
        drain();
    endtask

    // Fill the block while the receiver holds off, then pause the sender.
    task automatic test_pressure();
        write_reg(CFG_DISCARD, 16'd8);
        write_reg(CFG_MAX_RUNS, 16'd10);
        recv_hold = 800;
        for (int n = 0; n < 16; n++)
            send_item(n[0] ? MODE_W64 : MODE_RUN, 8'd0, 1'b0, 7'd3);
        drain();
        send_item(MODE_W32);
        drain();
    endtask

    task automatic test_random_phase(int idle, int stall, logic [15:0] runs,
                                     logic [15:0] ivl, logic [15:0] disc, int items);
        int sent;
        int r;
        int len;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        write_reg(CFG_MAX_RUNS, runs);
        write_reg(CFG_INTERVAL, ivl);
        write_reg(CFG_DISCARD, disc);
        sent = 0;
        while (sent < items)
        begin
            r = $urandom_range(99);
            if (r < 6)
            begin
                len = $urandom_range(1, 40);
                load_key(len);
                sent += len;
            end
            else
            begin
                if (r < 30)
                    send_item(MODE_TICK);
                else if (r < 35)
                    send_item(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom),
                              7'($urandom));
                else if (r < 55)
                    send_item(MODE_W32);
                else if (r < 75)
                    send_item(MODE_W64);
                else if (r < 92)
                    send_item(MODE_RUN, 8'd0, 1'b0, 7'($urandom_range(1, 8)));
                else
                    send_item(MODE_RUN, 8'($urandom), 1'($urandom),
                              7'($urandom_range(0, 127)));
                sent++;
            end
        end
        send_item(MODE_W32);
        drain();
    endtask

    // Test sequence.
    initial
    begin
        model_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_directed();
        test_pressure();
        test_random_phase(0, 0, 16'd12, 16'd6, 16'd20, 80);
        test_random_phase(54, 0, 16'd0, 16'd0, 16'd0, 70);
        test_random_phase(0, 54, 16'd1, 16'd1, 16'd4095, 50);
        test_random_phase(35, 35, 16'd30, 16'd3, 16'hF00D, 80);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Run time limit.
    initial
    begin
        #200_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
rtl/rrg_pkg.sv
rtl/rrg_front.sv
rtl/rrg_outq.sv
rtl/rrg_core.sv
rtl/rc4_reseeding_random_generator_unit.sv
dv/rc4_reseeding_random_generator_unit_test.sv
